// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and codes for the first-fit heap allocator
// Status codes, request kinds, sequencer states and the granule size.
// ----------------------------------------------------------------------------
package ffha_pkg;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOMEM   = 2'd1,
      STATUS_BADPTR  = 2'd2,
      STATUS_IGNORED = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_SPLIT,
      ST_F_RD,
      ST_F_CHK,
      ST_M_RD,
      ST_M_CHK,
      ST_M_NXT,
      ST_M_FOL,
      ST_M_CLR,
      ST_DONE
   } state_type;

   localparam int unsigned GRANULE_BYTES = 16;
   localparam int unsigned GRANULE_SHIFT = 4;

endpackage

// ----- sv/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram: single-port synchronous RAM
// One address per cycle, read every cycle and written when wr_en is set; read data registered.
// ----------------------------------------------------------------------------
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/first_fit_heap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator, split and coalesce
// Block headers live in one RAM entry per granule: {head, avail, len}.
//
//  channel | dir | tdata fields (low bit up)                          | tuser
//  req_    | in  | kind, request_bytes, payload_offset (pad to 40)    | -
//  rsp_    | out | status, granted_offset, granted_bytes, used_bytes  | -
//
// After reset a clearing pass writes HEAP_GRANULES entries, one a cycle.
// Allocate: walk block headers from granule 0 (read, check), split the fit if
// the rest can hold a header and a granule, then load the response. Free: read
// and check the header, then a full merge walk joins free headers with free followers.
// The single RAM port bounds the rate; one request at a time. The response
// waits in an output register; the next request is taken after it leaves.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
   parameter int HEAP_GRANULES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // kind, request_bytes, payload_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status, granted_offset, granted_bytes, used_bytes
);

   localparam int AW = $clog2(HEAP_GRANULES);
   localparam int LW = AW + 1;
   localparam int MW = LW + 2;
   localparam int TW = AW + 5;
   localparam logic [LW-1:0] HEAP_L = LW'(HEAP_GRANULES);

   ffha_pkg::state_type state_ff, state_in;

   logic [AW-1:0] addr;
   logic          wr_en;
   logic [MW-1:0] wr_data, rd_data;

   logic          m_head, m_avail;
   logic [LW-1:0] m_len;
   assign {m_head, m_avail, m_len} = rd_data;

   logic [LW-1:0] g_ff, g_in;
   logic [LW-1:0] cur_len_ff, cur_len_in;
   logic [LW-1:0] need_ff, need_in;
   logic [TW-1:0] total_ff, total_in;
   logic [15:0]   tot16;
   logic [1:0]    st_ff, st_in;
   logic [15:0]   goff_ff, goff_in, gby_ff, gby_in;
   logic [15:0]   offs_ff, offs_in;
   logic          out_v_ff, out_v_in;
   logic [55:0]   out_d_ff, out_d_in;

   logic [LW-1:0] nxt;
   logic [LW-1:0] chk_nxt;
   logic [LW+1:0] need_plus2;
   logic [16:0]   seg;
   logic          seg_bad;

   assign nxt        = g_ff + LW'(1) + cur_len_ff;
   assign chk_nxt    = g_ff + LW'(1) + m_len;
   assign need_plus2 = (LW+2)'(need_ff) + (LW+2)'(2);
   assign seg        = 17'(offs_ff[15:4]) - 17'd1;
   assign seg_bad    = (offs_ff[3:0] != 4'd0) || (seg >= 17'(HEAP_GRANULES));
   assign tot16      = (total_ff > TW'(16'hFFFF)) ? 16'hFFFF : total_ff[15:0];

   ffha_ram #(.WIDTH(MW), .DEPTH(2 ** AW)) u_marks (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(wr_data),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == ffha_pkg::ST_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_CLEAR;
         g_ff     <= '0;
         total_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         g_ff     <= g_in;
         total_ff <= total_in;
         out_v_ff <= out_v_in;
      end
      cur_len_ff <= cur_len_in;
      need_ff    <= need_in;
      st_ff      <= st_in;
      goff_ff    <= goff_in;
      gby_ff     <= gby_in;
      offs_ff    <= offs_in;
      out_d_ff   <= out_d_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffha_pkg::ST_CLEAR:
            if (g_ff == HEAP_L - LW'(1)) state_in = ffha_pkg::ST_IDLE;
         ffha_pkg::ST_IDLE:
            if (req_tvalid && req_tready) begin
               if (req_tdata[0] == ffha_pkg::KIND_ALLOC) begin
                  state_in = (req_tdata[16:1] == 16'd0) ? ffha_pkg::ST_DONE
                                                        : ffha_pkg::ST_A_RD;
               end else begin
                  state_in = (req_tdata[32:17] == 16'd0) ? ffha_pkg::ST_DONE
                                                         : ffha_pkg::ST_F_RD;
               end
            end
         ffha_pkg::ST_A_RD:
            state_in = (g_ff >= HEAP_L) ? ffha_pkg::ST_DONE : ffha_pkg::ST_A_CHK;
         ffha_pkg::ST_A_CHK:
            if (m_avail && m_len >= need_ff) begin
               state_in = ((LW+2)'(m_len) >= need_plus2) ? ffha_pkg::ST_A_SPLIT
                                                          : ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_A_RD;
            end
         ffha_pkg::ST_A_SPLIT: state_in = ffha_pkg::ST_DONE;
         ffha_pkg::ST_F_RD:
            state_in = seg_bad ? ffha_pkg::ST_DONE : ffha_pkg::ST_F_CHK;
         ffha_pkg::ST_F_CHK:
            state_in = (!m_head || m_avail) ? ffha_pkg::ST_DONE : ffha_pkg::ST_M_RD;
         ffha_pkg::ST_M_RD:
            state_in = (g_ff >= HEAP_L) ? ffha_pkg::ST_DONE : ffha_pkg::ST_M_CHK;
         ffha_pkg::ST_M_CHK:
            state_in = (m_avail && chk_nxt < HEAP_L) ? ffha_pkg::ST_M_NXT
                                                     : ffha_pkg::ST_M_RD;
         ffha_pkg::ST_M_NXT: state_in = ffha_pkg::ST_M_FOL;
         ffha_pkg::ST_M_FOL:
            state_in = (m_head && m_avail) ? ffha_pkg::ST_M_CLR : ffha_pkg::ST_M_RD;
         ffha_pkg::ST_M_CLR: state_in = ffha_pkg::ST_M_RD;
         ffha_pkg::ST_DONE: state_in = ffha_pkg::ST_IDLE;
         default: state_in = ffha_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      g_in       = g_ff;
      cur_len_in = cur_len_ff;
      need_in    = need_ff;
      total_in   = total_ff;
      st_in      = st_ff;
      goff_in    = goff_ff;
      gby_in     = gby_ff;
      offs_in    = offs_ff;
      out_v_in   = out_v_ff && !rsp_tready;
      out_d_in   = out_d_ff;
      addr       = g_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_data    = '0;
      unique case (state_ff)
         ffha_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = (g_ff == '0) ? {1'b1, 1'b1, HEAP_L - LW'(1)} : '0;
            g_in    = (g_ff == HEAP_L - LW'(1)) ? '0 : g_ff + LW'(1);
         end
         ffha_pkg::ST_IDLE: begin
            need_in = LW'((17'(req_tdata[16:1]) + 17'd15) >> 4);
            offs_in = req_tdata[32:17];
            st_in   = ffha_pkg::STATUS_IGNORED;
            goff_in = '0;
            gby_in  = '0;
            g_in    = '0;
         end
         ffha_pkg::ST_A_RD: begin
            if (g_ff >= HEAP_L) st_in = ffha_pkg::STATUS_NOMEM;
         end
         ffha_pkg::ST_A_CHK: begin
            if (m_avail && m_len >= need_ff) begin
               if ((LW+2)'(m_len) >= need_plus2) begin
                  cur_len_in = m_len;
                  wr_data    = {1'b1, 1'b0, need_ff};
               end else begin
                  wr_data    = {1'b1, 1'b0, m_len};
               end
               wr_en   = 1'b1;
               st_in   = ffha_pkg::STATUS_OK;
               total_in = total_ff + ((TW'(wr_data[LW-1:0])) << 4);
               goff_in = 16'((g_ff + LW'(1)) << 4);
               gby_in  = ((TW'(wr_data[LW-1:0]) << 4) > TW'(16'hFFFF)) ? 16'hFFFF
                         : 16'(wr_data[LW-1:0] << 4);
            end else begin
               g_in = chk_nxt;
            end
         end
         ffha_pkg::ST_A_SPLIT: begin
            addr    = AW'(g_ff + LW'(1) + need_ff);
            wr_en   = 1'b1;
            wr_data = {1'b1, 1'b1, cur_len_ff - need_ff - LW'(1)};
         end
         ffha_pkg::ST_F_RD: begin
            addr = seg[AW-1:0];
            g_in = LW'(seg);
            st_in = ffha_pkg::STATUS_BADPTR;
         end
         ffha_pkg::ST_F_CHK: begin
            if (m_head && !m_avail) begin
               wr_en    = 1'b1;
               wr_data  = {1'b1, 1'b1, m_len};
               cur_len_in = m_len;
               st_in    = ffha_pkg::STATUS_OK;
               total_in = (total_ff >= (TW'(m_len) << 4)) ? total_ff - (TW'(m_len) << 4)
                                                          : '0;
               g_in     = '0;
            end
         end
         ffha_pkg::ST_M_CHK: begin
            cur_len_in = m_len;
            if (!(m_avail && chk_nxt < HEAP_L)) begin
               g_in = chk_nxt;
            end
         end
         ffha_pkg::ST_M_NXT: begin
            addr = nxt[AW-1:0];
         end
         ffha_pkg::ST_M_FOL: begin
            if (m_head && m_avail) begin
               wr_en   = 1'b1;
               wr_data = {1'b1, 1'b1, cur_len_ff + LW'(1) + m_len};
            end else begin
               g_in = nxt;
            end
         end
         ffha_pkg::ST_M_CLR: begin
            addr    = nxt[AW-1:0];
            wr_en   = 1'b1;
            wr_data = '0;
         end
         ffha_pkg::ST_DONE: begin
            out_v_in = 1'b1;
            out_d_in = {6'd0, tot16, gby_ff, goff_ff, st_ff};
         end
         default: ;
      endcase
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata));
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid));
   a_accept_drop: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready);
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffha_pkg::ST_DONE |-> !out_v_ff);
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= (TW'(HEAP_GRANULES) << ffha_pkg::GRANULE_SHIFT));

endmodule

// ----- tb/sv/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker: request/response scoreboard for the first-fit heap allocator
// Watches both stream channels, keeps a shadow heap of block headers, predicts
// the response of every accepted request and compares each response field.
// ----------------------------------------------------------------------------
module ffha_checker #(
   parameter int HEAP_GRANULES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [15:0] used_bytes;
      logic [15:0] granted_bytes;
      logic [15:0] granted_offset;
      ffha_pkg::status_type status;
   } heap_rsp_t;

   bit          shadow_head  [HEAP_GRANULES];
   bit          shadow_avail [HEAP_GRANULES];
   int unsigned shadow_len   [HEAP_GRANULES];
   longint unsigned shadow_used;
   heap_rsp_t   expected_rsps [$];

   function automatic logic [15:0] sat16(longint unsigned v);
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
   endfunction

   function automatic void coalesce_free();
      int unsigned g;
      int unsigned nxt;
      g = 0;
      while (g < HEAP_GRANULES) begin
         nxt = g + 1 + shadow_len[g];
         if (shadow_avail[g] && nxt < HEAP_GRANULES &&
             shadow_head[nxt] && shadow_avail[nxt]) begin
            shadow_len[g] += 1 + shadow_len[nxt];
            shadow_head[nxt] = 0;
            shadow_avail[nxt] = 0;
            shadow_len[nxt] = 0;
         end else begin
            g = nxt;
         end
      end
   endfunction

   function automatic heap_rsp_t predict_heap(ffha_pkg::kind_type kind, logic [15:0] nbytes,
                                              logic [15:0] offset);
      heap_rsp_t r;
      int unsigned need;
      int unsigned g;
      int unsigned ng;
      bit found;
      longint unsigned b;
      r = '0;
      r.status = ffha_pkg::STATUS_OK;
      if (kind == ffha_pkg::KIND_ALLOC) begin
         if (nbytes == 0) begin
            r.status = ffha_pkg::STATUS_IGNORED;
         end else begin
            need = (int'(nbytes) + ffha_pkg::GRANULE_BYTES - 1) / ffha_pkg::GRANULE_BYTES;
            g = 0;
            found = 0;
            while (g < HEAP_GRANULES && !found) begin
               if (shadow_avail[g] && shadow_len[g] >= need) begin
                  if (shadow_len[g] >= need + 2) begin
                     ng = g + 1 + need;
                     shadow_head[ng] = 1;
                     shadow_avail[ng] = 1;
                     shadow_len[ng] = shadow_len[g] - need - 1;
                     shadow_len[g] = need;
                  end
                  shadow_avail[g] = 0;
                  shadow_used += shadow_len[g] * ffha_pkg::GRANULE_BYTES;
                  r.granted_offset = 16'((g + 1) * ffha_pkg::GRANULE_BYTES);
                  r.granted_bytes = sat16(shadow_len[g] * ffha_pkg::GRANULE_BYTES);
                  found = 1;
               end else begin
                  g += 1 + shadow_len[g];
               end
            end
            if (!found) r.status = ffha_pkg::STATUS_NOMEM;
         end
      end else begin
         if (offset == 0) begin
            r.status = ffha_pkg::STATUS_IGNORED;
         end else if (offset % ffha_pkg::GRANULE_BYTES != 0 ||
                      offset / ffha_pkg::GRANULE_BYTES - 1 >= HEAP_GRANULES) begin
            r.status = ffha_pkg::STATUS_BADPTR;
         end else begin
            g = offset / ffha_pkg::GRANULE_BYTES - 1;
            if (!shadow_head[g] || shadow_avail[g]) begin
               r.status = ffha_pkg::STATUS_BADPTR;
            end else begin
               b = shadow_len[g] * ffha_pkg::GRANULE_BYTES;
               shadow_avail[g] = 1;
               shadow_used = (shadow_used >= b) ? shadow_used - b : 0;
               coalesce_free();
            end
         end
      end
      r.used_bytes = sat16(shadow_used);
      return r;
   endfunction

   always @(posedge clock) begin
      heap_rsp_t got;
      heap_rsp_t want;
      if (reset) begin
         for (int i = 0; i < HEAP_GRANULES; i++) begin
            shadow_head[i] = 0;
            shadow_avail[i] = 0;
            shadow_len[i] = 0;
         end
         shadow_head[0] = 1;
         shadow_avail[0] = 1;
         shadow_len[0] = HEAP_GRANULES - 1;
         shadow_used = 0;
         expected_rsps.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rsps.push_back(predict_heap(ffha_pkg::kind_type'(req_tdata[0]),
                                                 req_tdata[16:1], req_tdata[32:17]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[49:0];
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %h", rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want || rsp_tdata[55:50] !== 0) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp st=%0d off=%0d len=%0d used=%0d,",
                               " got st=%0d off=%0d len=%0d used=%0d"},
                              want.status, want.granted_offset, want.granted_bytes,
                              want.used_bytes, got.status, got.granted_offset,
                              got.granted_bytes, got.used_bytes);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_rsps.size();
      end
   end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the first-fit heap allocator
// Drives allocate and free requests in random bursts, some of them frees of live
// blocks, plus null, zero, misaligned, interior and double-free requests.
// ----------------------------------------------------------------------------
module tb;

   localparam int HEAP_GRANULES = 4096;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   logic [15:0] live_offsets [$];
   int          idx;

   first_fit_heap_allocator_unit #(.HEAP_GRANULES(HEAP_GRANULES)) i_dut (.*);

   ffha_checker #(.HEAP_GRANULES(HEAP_GRANULES)) i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 3) == 0) rsp_tready <= 1;
         else rsp_tready <= ($urandom_range(0, 9) < 6);
      end
   end

   // track live blocks from responses
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready && rsp_tdata[1:0] == ffha_pkg::STATUS_OK &&
          rsp_tdata[17:2] != 0)
         live_offsets.push_back(rsp_tdata[17:2]);

   task automatic send_request(ffha_pkg::kind_type kind, logic [15:0] nbytes,
                               logic [15:0] offset);
      req_tvalid <= 1;
      req_tdata <= {7'd0, offset, nbytes, kind};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 4);
      if (n > 0) begin
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int burst;
      logic [15:0] off;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (10) @(posedge clock);
      reset <= 0;

      send_request(ffha_pkg::KIND_ALLOC, 16'd0, 16'hFFFF);
      send_request(ffha_pkg::KIND_FREE, 16'hFFFF, 16'd0);
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'hFFFF);
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd24);
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd16);
      send_request(ffha_pkg::KIND_ALLOC, 16'd1, 16'd0);
      send_request(ffha_pkg::KIND_ALLOC, 16'd16, 16'd0);
      send_request(ffha_pkg::KIND_ALLOC, 16'd17, 16'd0);
      send_request(ffha_pkg::KIND_ALLOC, 16'hFFFF, 16'd0);
      send_request(ffha_pkg::KIND_ALLOC, 16'd1000, 16'd0);
      wait_drained();
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd16);
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd16);
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd64);
      send_request(ffha_pkg::KIND_FREE, 16'd0, 16'd48);
      send_request(ffha_pkg::KIND_ALLOC, 16'd40, 16'd0);
      send_request(ffha_pkg::KIND_ALLOC, 16'd65504, 16'd0);
      send_request(ffha_pkg::KIND_ALLOC, 16'd65520, 16'd0);
      wait_drained();
      live_offsets.delete();

      for (int n = 0; n < 270; ) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++, n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: send_request(ffha_pkg::KIND_ALLOC,
                  ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 3000)),
                  16'($urandom));
               4, 5, 6: begin
                  wait_drained();
                  if (live_offsets.size() != 0) begin
                     idx = $urandom_range(0, live_offsets.size() - 1);
                     off = live_offsets[idx];
                     live_offsets.delete(idx);
                  end else off = 16'($urandom);
                  send_request(ffha_pkg::KIND_FREE, 16'($urandom), off);
               end
               7: send_request(ffha_pkg::KIND_FREE, 16'($urandom),
                               16'($urandom_range(0, 8) * 16));
               8: send_request(ffha_pkg::KIND_FREE, 16'($urandom), 16'($urandom));
               default: send_request(ffha_pkg::kind_type'($urandom_range(0, 1)),
                                     16'($urandom), 16'($urandom));
            endcase
         end
         if (n > 130 && n < 145) wait_drained();
         else idle_gap();
      end
      wait_drained();
      repeat (50000) @(posedge clock);
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #200000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/first_fit_heap_allocator_unit.sv
tb/sv/ffha_checker.sv
tb/sv/tb.sv
